### design/esd_pkg.sv
// Shared types and constants of the energy speech detector.
package esd_pkg;

  // Item kinds carried in the input tuser field.
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_ENERGY_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_START_FRAMES     = 2'd1;
  localparam logic [1:0] REG_SILENCE_MS       = 2'd2;

  localparam int THR_W    = 15;
  localparam int RUN_W    = 8;
  localparam int QUIET_W  = 16;
  localparam int CFG_W    = 16;
  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = SAMPLE_W + 1;
  localparam int SQ_W     = 31;
  localparam int THR_SQ_W = 2 * THR_W;
  localparam int SUM_W    = 40;

  localparam logic [THR_W-1:0]   THRESHOLD_RESET    = 15'd1100;
  localparam logic [RUN_W-1:0]   START_FRAMES_RESET = 8'd3;
  localparam logic [QUIET_W-1:0] SILENCE_MS_RESET   = 16'd5000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // register an accepted sample
    logic tick;       // millisecond tick
    logic clear;      // clear detector state
    logic square;     // square the sample and the threshold
    logic accum;      // add the square into the frame sum
    logic mul_limit;  // form threshold squared times sample count
    logic decide;     // close the frame and load the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic frame_last; // the sample being accumulated closes its frame
    logic out_busy;   // the result register holds a request not yet taken
  } sts_t;

endpackage

### design/esd_ctrl.sv
// Sequencer that steps each accepted item through the detector datapath.
module esd_ctrl
  import esd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [1:0] s_axis_tuser,
  input  sts_t       sts,
  output cmd_t       cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SQUARE = 3'd1;
  localparam logic [2:0] ST_ACCUM  = 3'd2;
  localparam logic [2:0] ST_LIMIT  = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (s_axis_tuser)
            KIND_SAMPLE: begin
              cmd.capture = 1'b1;
              state_next  = ST_SQUARE;
            end
            KIND_TICK:  cmd.tick  = 1'b1;
            KIND_CLEAR: cmd.clear = 1'b1;
            default: ;
          endcase
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = sts.frame_last ? ST_LIMIT : ST_IDLE;
      end
      ST_LIMIT: begin
        cmd.mul_limit = 1'b1;
        state_next    = ST_DECIDE;
      end
      ST_DECIDE: begin
        // The result waits here until the output register is free.
        if (!sts.out_busy) begin
          cmd.decide = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### design/esd_datapath.sv
// Frame energy accumulator, threshold compare and speech/silence tracking.
module esd_datapath
  import esd_pkg::*;
#(
  parameter int MAX_FRAME_SAMPLES = 512
)
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                frame_end,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic                m_tready,
  output logic                m_tvalid,
  output logic [7:0]          m_tdata
);

  localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int LIM_W = THR_SQ_W + CNT_W;
  localparam int CMP_W = (LIM_W > SUM_W) ? LIM_W : SUM_W;

  logic [THR_W-1:0]    energy_threshold;
  logic [RUN_W-1:0]    start_frames;
  logic [QUIET_W-1:0]  silence_ms;

  logic [SAMPLE_W-1:0] sample_q;
  logic                frame_end_q;
  logic [SQ_W-1:0]     sq;
  logic [THR_SQ_W-1:0] thr_sq;
  logic [SUM_W-1:0]    energy_sum;
  logic [CNT_W-1:0]    frame_count;
  logic [LIM_W-1:0]    limit;
  logic [RUN_W-1:0]    speech_run;
  logic                detected_flag;
  logic [QUIET_W-1:0]  quiet_ms;
  logic [2:0]          result;

  logic [MAG_W-1:0]    mag;
  logic [2*MAG_W-1:0]  sq_full;
  logic [SUM_W:0]      sum_add;
  logic [CNT_W-1:0]    count_inc;
  logic                speech;
  logic [RUN_W-1:0]    run_inc;
  logic                confirm;
  logic                commit;

  // Magnitude of a two's-complement sample; -32768 yields 32768.
  assign mag = sample_q[SAMPLE_W-1] ? (MAG_W'(0) - {1'b1, sample_q}) : {1'b0, sample_q};
  assign sq_full   = mag * mag;
  assign sum_add   = {1'b0, energy_sum} + (SUM_W + 1)'(sq);
  assign count_inc = frame_count + 1'b1;

  assign sts.frame_last = frame_end_q || (count_inc >= CNT_W'(MAX_FRAME_SAMPLES));
  assign sts.out_busy   = m_tvalid && !m_tready;

  assign speech  = CMP_W'(energy_sum) > CMP_W'(limit);
  assign run_inc = (speech_run < start_frames) ? speech_run + 1'b1 : speech_run;
  assign confirm = speech && (run_inc >= start_frames);
  assign commit  = !speech && detected_flag && (quiet_ms >= silence_ms);

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_threshold <= THRESHOLD_RESET;
      start_frames     <= START_FRAMES_RESET;
      silence_ms       <= SILENCE_MS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENERGY_THRESHOLD: energy_threshold <= cfg_data[THR_W-1:0];
        REG_START_FRAMES:     start_frames     <= cfg_data[RUN_W-1:0];
        REG_SILENCE_MS:       silence_ms       <= cfg_data[QUIET_W-1:0];
        default: ;
      endcase
    end
  end

  // Payload pipeline registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_q    <= sample;
      frame_end_q <= frame_end;
    end
    if (cmd.square) begin
      sq     <= sq_full[SQ_W-1:0];
      thr_sq <= energy_threshold * energy_threshold;
    end
    if (cmd.mul_limit) begin
      limit <= thr_sq * frame_count;
    end
    if (cmd.decide) begin
      result <= {commit, confirm || (detected_flag && !commit), speech};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      energy_sum    <= '0;
      frame_count   <= '0;
      speech_run    <= '0;
      detected_flag <= 1'b0;
      quiet_ms      <= '0;
    end else begin
      if (cmd.tick && quiet_ms != {QUIET_W{1'b1}}) begin
        quiet_ms <= quiet_ms + 1'b1;
      end
      if (cmd.accum) begin
        energy_sum  <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
        frame_count <= count_inc;
      end
      if (cmd.decide) begin
        energy_sum  <= '0;
        frame_count <= '0;
        if (speech) begin
          speech_run <= run_inc;
          if (confirm) begin
            detected_flag <= 1'b1;
            quiet_ms      <= '0;
          end
        end else begin
          speech_run <= '0;
          if (commit) begin
            detected_flag <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.decide) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {5'd0, result};

endmodule

### design/energy_speech_detector_core.sv
// Top level of the energy-based speech detector.
// Takes a stream of items whose tuser selects an audio sample, a millisecond tick or a clear
// command. Ticks, clears and unused kinds are done when accepted. A sample inside a frame steps
// through accept, square and accumulate, and the sample that closes a frame also through the
// limit multiply and the compare, since one sequencer steps each sample through one pair of
// squaring multipliers and one 40-bit accumulator. A frame closes on tlast or by itself on its
// MAX_FRAME_SAMPLES-th sample; it then yields one result request with the frame's speech
// decision, the confirmed-speech state and the commit flag. A closing sample waits while an
// earlier result has not been taken. Registers are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle, as the block does not enforce it.
module energy_speech_detector_core
  import esd_pkg::*;
#(
  parameter int MAX_FRAME_SAMPLES = 512
)
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [SAMPLE_W-1:0] s_axis_tdata,   // [15:0] sample
  input  logic [1:0]          s_axis_tuser,   // [1:0] kind
  input  logic                s_axis_tlast,   // frame_end
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata    // [0] frame_speech, [1] speech_confirmed,
                                              // [2] commit_flag, [7:3] zero
);

  cmd_t cmd;
  sts_t sts;

  esd_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .sts           (sts),
    .cmd           (cmd)
  );

  esd_datapath #(
    .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (s_axis_tdata),
    .frame_end (s_axis_tlast),
    .cmd       (cmd),
    .sts       (sts),
    .m_tready  (m_axis_tready),
    .m_tvalid  (m_axis_tvalid),
    .m_tdata   (m_axis_tdata)
  );

  // The sequencer issues at most one step per cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.tick, cmd.clear, cmd.square, cmd.accum, cmd.mul_limit,
              cmd.decide}))
    else $error("more than one datapath command at once");

  // A new result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("result loaded while the output register is busy");

  // An accepted sample blocks the input until its steps are done.
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_SAMPLE) |=> !s_axis_tready)
    else $error("input ready right after a sample request");

  // A commit comes only on a silent frame and ends the detection.
  a_commit_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[2]) |-> (!m_axis_tdata[0] && !m_axis_tdata[1]))
    else $error("commit with speech or confirmed detection");

endmodule

### sim/tb_top.sv
// Self-checking testbench for the energy speech detector core.
`timescale 1ns / 100ps

module tb_top
  import esd_pkg::*;
();

  localparam int MAX_FRAME = 512;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_PHASE_ITEMS = 120;
  localparam int LONG_SILENCE_MS = 90;
  localparam int LONG_TICK_RUN = 100;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [63:0] ENERGY_CEILING = (64'd1 << SUM_W) - 64'd1;

  // Bit order matches the result tdata: frame_speech in bit 0.
  typedef struct packed {
    logic commit_flag;
    logic speech_confirmed;
    logic frame_speech;
  } verdict_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [1:0]          cfg_index;
  logic [CFG_W-1:0]    cfg_data;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [SAMPLE_W-1:0] s_axis_tdata;   // [15:0] sample
  logic [1:0]          s_axis_tuser;   // [1:0] kind
  logic                s_axis_tlast;   // frame_end
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [7:0]          m_axis_tdata;   // [0] frame_speech, [1] speech_confirmed,
                                       // [2] commit_flag, [7:3] zero

  energy_speech_detector_core #(
    .MAX_FRAME_SAMPLES(MAX_FRAME)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // Detector state and registers as the block should hold them.
  logic [THR_W-1:0]   cur_threshold;
  logic [RUN_W-1:0]   cur_start_frames;
  logic [QUIET_W-1:0] cur_silence_ms;
  logic [SUM_W-1:0]   acc_energy;
  int unsigned        acc_samples;
  logic [RUN_W-1:0]   run_len;
  logic               confirmed;
  logic [QUIET_W-1:0] quiet_count;

  verdict_t verdict_q[$];
  string    field_names[3] = '{"frame_speech", "speech_confirmed", "commit_flag"};

  int  errors = 0;
  int  n_items = 0;
  int  n_results = 0;
  int  n_commits = 0;
  int  cycle_count = 0;
  bit  no_idle = 1'b0;
  int  hold_seq = 0;

  function automatic void clear_detector_state();
    acc_energy  = '0;
    acc_samples = 0;
    run_len     = '0;
    confirmed   = 1'b0;
    quiet_count = '0;
  endfunction

  // Applies one accepted request to the detector state and queues the verdict
  // when a frame closes.
  function automatic void predict_verdict(input logic [1:0] kind, input logic [15:0] smp,
                                          input logic frame_end);
    logic [16:0] mag;
    logic [63:0] sum;
    logic [63:0] limit;
    logic        closing;
    verdict_t    v;
    case (kind)
      KIND_TICK: begin
        if (quiet_count != '1) quiet_count++;
      end
      KIND_CLEAR: begin
        clear_detector_state();
      end
      KIND_SAMPLE: begin
        mag = smp[15] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
        sum = {24'd0, acc_energy} + 64'(mag) * 64'(mag);
        if (sum > ENERGY_CEILING) sum = ENERGY_CEILING;
        acc_energy = sum[SUM_W-1:0];
        acc_samples++;
        closing = frame_end || (acc_samples >= MAX_FRAME);
        if (closing) begin
          limit = 64'(cur_threshold) * 64'(cur_threshold) * 64'(acc_samples);
          v = '0;
          v.frame_speech = ({24'd0, acc_energy} > limit);
          acc_energy  = '0;
          acc_samples = 0;
          if (v.frame_speech) begin
            if (run_len < cur_start_frames) run_len++;
            if (run_len >= cur_start_frames) begin
              confirmed   = 1'b1;
              quiet_count = '0;
            end
          end else begin
            run_len = '0;
            if (confirmed && quiet_count >= cur_silence_ms) begin
              v.commit_flag = 1'b1;
              confirmed     = 1'b0;
            end
          end
          v.speech_confirmed = confirmed;
          verdict_q.push_back(v);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [15:0] make_sample(input int unsigned lo, input int unsigned hi);
    int unsigned mag;
    mag = $urandom_range(hi, lo);
    if (mag >= 32768) return 16'h8000;
    if ($urandom_range(1)) return 16'(0 - mag);
    return 16'(mag);
  endfunction

  // Entered just after a rising edge; returns at the edge that accepts the request.
  task automatic send_item(input logic [1:0] kind, input logic [15:0] data,
                           input logic frame_end);
    @(negedge clk);
    if (!no_idle) begin
      while ($urandom_range(99) < 20) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= data;
    s_axis_tlast  <= frame_end;
    do @(posedge clk); while (!s_axis_tready);
    n_items++;
    predict_verdict(kind, data, frame_end);
  endtask

  task automatic send_frame(input int len, input int unsigned lo, input int unsigned hi,
                            input logic close);
    for (int i = 0; i < len; i++)
      send_item(KIND_SAMPLE, make_sample(lo, hi), close && (i == len - 1));
  endtask

  // The sender stops and waits for every queued verdict, then lets the
  // pipeline run dry of requests that produce no result.
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_ENERGY_THRESHOLD: cur_threshold    = val[THR_W-1:0];
      REG_START_FRAMES:     cur_start_frames = val[RUN_W-1:0];
      REG_SILENCE_MS:       cur_silence_ms   = val[QUIET_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int unsigned thr, input int unsigned frames,
                            input int unsigned silence);
    settle();
    write_reg(REG_ENERGY_THRESHOLD, 16'(thr));
    write_reg(REG_START_FRAMES, 16'(frames));
    write_reg(REG_SILENCE_MS, 16'(silence));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Reset values: boundary at the threshold itself, confirmation after three
  // frames, ticks and clears between frames, and an unused kind.
  task automatic test_reset_defaults();
    send_item(KIND_SAMPLE, 16'd0, 1'b1);
    send_item(KIND_SAMPLE, 16'h8000, 1'b1);
    send_item(KIND_SAMPLE, 16'h7FFF, 1'b0);
    send_item(KIND_SAMPLE, 16'hFFFF, 1'b1);
    send_item(KIND_SAMPLE, 16'd1101, 1'b1);
    send_item(KIND_SAMPLE, 16'd1100, 1'b1);
    send_item(KIND_UNUSED, 16'hFFFF, 1'b1);
    send_item(KIND_TICK, 16'hA5A5, 1'b0);
    send_item(KIND_SAMPLE, 16'h8001, 1'b1);
    send_item(KIND_CLEAR, 16'h5A5A, 1'b1);
    send_item(KIND_SAMPLE, 16'h7FFF, 1'b1);
  endtask

  task automatic test_threshold_extremes();
    set_config(0, 2, 100);
    send_item(KIND_SAMPLE, 16'd0, 1'b1);
    send_item(KIND_SAMPLE, 16'd1, 1'b1);
    send_item(KIND_SAMPLE, 16'hFFFF, 1'b1);
    set_config(32767, 2, 100);
    send_item(KIND_SAMPLE, 16'h8000, 1'b1);
    send_item(KIND_SAMPLE, 16'h7FFF, 1'b1);
  endtask

  // Zero start frames confirms on the first speech frame; zero silence commits
  // on the first quiet frame; a clear drops a confirmed detection silently.
  task automatic test_commit_corners();
    set_config(1100, 0, 0);
    send_item(KIND_SAMPLE, 16'h7FFF, 1'b1);
    send_item(KIND_SAMPLE, 16'd0, 1'b1);
    set_config(1100, 1, 3);
    send_item(KIND_SAMPLE, 16'h7FFF, 1'b1);
    repeat (2) send_item(KIND_TICK, 16'd0, 1'b0);
    send_item(KIND_SAMPLE, 16'd0, 1'b1);
    send_item(KIND_TICK, 16'd0, 1'b0);
    send_item(KIND_SAMPLE, 16'd0, 1'b1);
    send_item(KIND_SAMPLE, 16'h8000, 1'b1);
    send_item(KIND_CLEAR, 16'd0, 1'b0);
    repeat (3) send_item(KIND_TICK, 16'd0, 1'b0);
    send_item(KIND_SAMPLE, 16'd0, 1'b1);
  endtask

  // A long unbroken run of ticks past the silence limit still commits on the
  // next quiet frame.
  task automatic test_long_silence();
    set_config(1100, 1, LONG_SILENCE_MS);
    no_idle = 1'b1;
    send_item(KIND_SAMPLE, 16'h7FFF, 1'b1);
    repeat (LONG_TICK_RUN) send_item(KIND_TICK, 16'($urandom), 1'($urandom));
    send_item(KIND_SAMPLE, 16'd0, 1'b1);
    no_idle = 1'b0;
  endtask

  // A full-scale frame with no end mark closes by itself at the sample limit.
  task automatic test_overlong_frames();
    set_config(32767, 1, 10);
    send_frame(MAX_FRAME, 32768, 32768, 1'b0);
    send_frame(3, 0, 32768, 1'b1);
  endtask

  // The receiver stalls for a long stretch while short frames keep coming,
  // so the result register fills and the input stalls behind it.
  task automatic test_backpressure();
    set_config(800, 2, 4);
    hold_seq++;
    repeat (40) begin
      send_frame(1, 0, 1600, 1'b1);
      send_item(KIND_TICK, 16'($urandom), 1'b0);
    end
    settle();
  endtask

  task automatic run_random_phase(input int n_target);
    int sent;
    int r;
    int len;
    int unsigned thr;
    int unsigned lo;
    int unsigned hi;
    logic close;
    sent = 0;
    while (sent < n_target) begin
      r = $urandom_range(99);
      if (r < 70) begin
        len = ($urandom_range(49) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
        thr = cur_threshold;
        if ($urandom_range(9) == 0) begin
          lo = 0;
          hi = 32768;
        end else if ($urandom_range(1)) begin
          lo = thr;
          hi = (2 * thr + 16 > 32768) ? 32768 : 2 * thr + 16;
        end else begin
          lo = 0;
          hi = thr;
        end
        // Now and then a frame loses its end mark and runs into the next one.
        close = ($urandom_range(19) != 0);
        send_frame(len, lo, hi, close);
        sent += len;
      end else if (r < 90) begin
        len = $urandom_range(6, 1);
        repeat (len) send_item(KIND_TICK, 16'($urandom), 1'($urandom));
        sent += len;
      end else if (r < 95) begin
        send_item(KIND_CLEAR, 16'($urandom), 1'($urandom));
        sent++;
      end else begin
        send_item(KIND_UNUSED, 16'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic test_random_traffic();
    set_config($urandom_range(4000, 200), $urandom_range(4, 1), $urandom_range(8, 1));
    run_random_phase(RANDOM_PHASE_ITEMS);
    set_config($urandom_range(32767), $urandom_range(6), $urandom_range(5));
    no_idle = 1'b1;
    run_random_phase(RANDOM_PHASE_ITEMS);
    no_idle = 1'b0;
    set_config($urandom_range(32767), $urandom_range(255), $urandom_range(65535));
    run_random_phase(RANDOM_PHASE_ITEMS);
    set_config($urandom_range(3000, 100), $urandom_range(3, 1), $urandom_range(6));
    run_random_phase(RANDOM_PHASE_ITEMS);
  endtask

  // Result side: random stalls, a counted long hold on request, or none at all.
  int hold_seen = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (no_idle) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= 20);
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    verdict_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = verdict_t'(m_axis_tdata[2:0]);
      if (verdict_q.size() == 0) begin
        $display("%0t: result with nothing expected, actual %b", $time, got);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (got[i] !== want[i]) begin
            $display("%0t: %s mismatch, expected %b, actual %b", $time, field_names[i],
                     want[i], got[i]);
            errors++;
          end
        end
        n_results++;
        if (want.commit_flag) n_commits++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, verdict_q.size());
      $display("[energy_speech_detector_core] ERROR");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_ENERGY_THRESHOLD;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_SAMPLE;
    s_axis_tlast  = 1'b0;
    cur_threshold    = THRESHOLD_RESET;
    cur_start_frames = START_FRAMES_RESET;
    cur_silence_ms   = SILENCE_MS_RESET;
    clear_detector_state();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_threshold_extremes();
    test_commit_corners();
    test_long_silence();
    test_overlong_frames();
    test_backpressure();
    test_random_traffic();
    settle();

    $display("Sent %0d requests; checked %0d frame verdicts, %0d of them commits.",
             n_items, n_results, n_commits);
    $display("Phases: reset values, threshold and commit corners, long silence, %s",
             "overlong frames, output hold-off, random traffic.");
    if (errors == 0) begin
      $display("[energy_speech_detector_core] OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("[energy_speech_detector_core] ERROR");
    end
    $finish;
  end

endmodule
